[rtl/core/amdfs_pkg.sv]
// Shared widths, codes and defaults for the adjacency matrix depth-first search block.
`timescale 1ns / 1ps

package amdfs_pkg;

	localparam int MAX_VERTICES_DEF = 32;

	localparam int KIND_W = 2;
	localparam int VTX_W  = 5;
	localparam int PRE_W  = 5;
	localparam int EDGE_W = 10;
	localparam int VC_W   = 6;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_SEARCH = 2'd2;
	localparam kind_t KIND_CLEAR  = 2'd3;

	localparam logic [APB_ADDR_W-1:0] REG_VERTEX_COUNT_ADDR = 3'h0;
	localparam logic [VC_W-1:0]       VERTEX_COUNT_RESET    = 6'd32;

endpackage

[rtl/core/adjacency_matrix_dfs_preorder.sv]
// Adjacency matrix store with edge edits and an iterative depth-first preorder search.
`timescale 1ns / 1ps

// Holds an undirected graph as a bit matrix (one memory row per vertex) plus an edge count,
// and takes one item at a time. Insert and remove read and rewrite both endpoint rows, one
// at a time through the matrix memory, then give the result beat; clear and an out-of-range
// edit go straight to the result beat. A search over n live vertices scans one neighbour
// bit a cycle against the visited set; each visit and each return to a parent rereads that
// vertex's row and rescans it from bit 0, so search time is bounded by the matrix read
// port and the bit-serial scan. It then delivers n beats, one per vertex in vertex order,
// each held while the output is stalled. vertex_count is clamped to 1..MAX_VERTICES. The item
// side is ready only while the block is idle; a delivered beat waits in an output register.
module adjacency_matrix_dfs_preorder #(
	parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [amdfs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [amdfs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [amdfs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [amdfs_pkg::KIND_W-1:0]        kind,
	input  logic [amdfs_pkg::VTX_W-1:0]         from_vertex,
	input  logic [amdfs_pkg::VTX_W-1:0]         to_vertex,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [amdfs_pkg::VTX_W-1:0]         vertex,
	output logic [amdfs_pkg::PRE_W-1:0]         preorder,
	output logic [amdfs_pkg::EDGE_W-1:0]        edge_count,
	output logic                                bad_vertex,
	output logic                                last
);
	import amdfs_pkg::*;

	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EA_RD   = 4'd1;
	localparam logic [3:0] S_EA_WR   = 4'd2;
	localparam logic [3:0] S_EB_RD   = 4'd3;
	localparam logic [3:0] S_EB_WR   = 4'd4;
	localparam logic [3:0] S_DONE    = 4'd5;
	localparam logic [3:0] S_ROOT    = 4'd6;
	localparam logic [3:0] S_READ    = 4'd7;
	localparam logic [3:0] S_SCAN    = 4'd8;
	localparam logic [3:0] S_POP     = 4'd9;
	localparam logic [3:0] S_RPT_RD  = 4'd10;
	localparam logic [3:0] S_RPT_OUT = 4'd11;

	logic [3:0]              state_q;
	logic [VC_W-1:0]         vertex_count_q;
	kind_t                   kind_q;
	logic [VTX_W-1:0]        a_q;
	logic [VTX_W-1:0]        b_q;
	logic [CW-1:0]           n_q;
	logic                    bad_q;
	logic [EDGE_W-1:0]       edges_q;
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [PRE_W-1:0]        cnt_q;
	logic [CW-1:0]           root_q;
	logic [CW-1:0]           depth_q;
	logic [IW-1:0]           top_q;
	logic [CW-1:0]           t_q;
	logic [CW-1:0]           v_q;

	logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_rd_q;
	logic                    row_vld_q;
	logic [PRE_W-1:0]        order_mem [MAX_VERTICES];
	logic [PRE_W-1:0]        order_rd_q;
	logic [IW-1:0]           stack_mem [MAX_VERTICES];
	logic [IW-1:0]           stack_rd_q;

	logic                    out_valid_q;
	logic [VTX_W-1:0]        vertex_q;
	logic [PRE_W-1:0]        preorder_q;
	logic [EDGE_W-1:0]       edge_count_q;
	logic                    bad_vertex_q;
	logic                    last_q;

	logic                    item_acc;
	logic                    cfg_we;
	logic [CW-1:0]           n_live;
	logic                    in_range;
	logic [IW-1:0]           a_ix;
	logic [IW-1:0]           b_ix;
	logic [IW-1:0]           t_ix;
	logic [IW-1:0]           root_ix;
	logic [MAX_VERTICES-1:0] row_eff;
	logic                    hit;
	logic                    can_push;
	logic                    row_re;
	logic [IW-1:0]           row_raddr;
	logic                    row_we;
	logic [IW-1:0]           row_waddr;
	logic [IW-1:0]           edit_ix;
	logic [MAX_VERTICES-1:0] edit_mask;
	logic [MAX_VERTICES-1:0] row_wdata;
	logic                    visit_en;
	logic [IW-1:0]           visit_ix;
	logic                    stack_re;
	logic [IW-1:0]           stack_raddr;
	logic                    order_re;
	logic                    out_free;
	logic                    out_load;
	logic [VTX_W-1:0]        load_vertex;
	logic [PRE_W-1:0]        load_preorder;
	logic                    load_bad;
	logic                    load_last;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && (paddr == REG_VERTEX_COUNT_ADDR);
	assign prdata   = (paddr == REG_VERTEX_COUNT_ADDR) ?
		APB_DATA_W'(vertex_count_q) : '0;

	assign item_ready = (state_q == S_IDLE);
	assign item_acc   = item_valid && item_ready;

	always_comb begin
		if (vertex_count_q == '0) begin
			n_live = CW'(1);
		end else if (int'(vertex_count_q) > MAX_VERTICES) begin
			n_live = CW'(MAX_VERTICES);
		end else begin
			n_live = CW'(vertex_count_q);
		end
	end

	assign in_range = (int'(from_vertex) < int'(n_live)) && (int'(to_vertex) < int'(n_live));

	assign a_ix    = IW'(a_q);
	assign b_ix    = IW'(b_q);
	assign t_ix    = IW'(t_q);
	assign root_ix = IW'(root_q);

	assign row_eff  = row_vld_q ? row_rd_q : '0;
	assign hit      = (t_q != n_q) && row_eff[t_ix] && !visited_q[t_ix];
	assign can_push = (depth_q < CW'(MAX_VERTICES));

	assign row_re    = (state_q == S_EA_RD) || (state_q == S_EB_RD) || (state_q == S_READ);
	assign row_raddr = (state_q == S_EA_RD) ? a_ix : ((state_q == S_EB_RD) ? b_ix : top_q);
	assign row_we    = (state_q == S_EA_WR) || (state_q == S_EB_WR);
	assign row_waddr = (state_q == S_EA_WR) ? a_ix : b_ix;
	assign edit_ix   = (state_q == S_EA_WR) ? b_ix : a_ix;
	assign edit_mask = MAX_VERTICES'(1) << edit_ix;
	assign row_wdata = (kind_q == KIND_INSERT) ? (row_eff | edit_mask) : (row_eff & ~edit_mask);

	assign visit_en = ((state_q == S_ROOT) && (root_q != n_q) && !visited_q[root_ix]) ||
		((state_q == S_SCAN) && hit && can_push);
	assign visit_ix = (state_q == S_ROOT) ? root_ix : t_ix;

	assign stack_re    = (state_q == S_SCAN) && !(hit && can_push) && (depth_q > CW'(1));
	assign stack_raddr = IW'(depth_q - CW'(2));
	assign order_re    = (state_q == S_RPT_RD);

	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		out_load      = 1'b0;
		load_vertex   = '0;
		load_preorder = '0;
		load_bad      = 1'b0;
		load_last     = 1'b1;
		case (state_q)
			S_DONE: begin
				out_load = out_free;
				load_bad = bad_q;
			end
			S_RPT_OUT: begin
				out_load      = out_free;
				load_vertex   = VTX_W'(v_q);
				load_preorder = order_rd_q;
				load_last     = (v_q + CW'(1) == n_q);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// matrix, visit order and walk stack memories
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q <= row_mem[row_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (visit_en) begin
			order_mem[visit_ix] <= cnt_q;
		end
		if (order_re) begin
			order_rd_q <= order_mem[IW'(v_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (visit_en) begin
			stack_mem[IW'(depth_q)] <= visit_ix;
		end
		if (stack_re) begin
			stack_rd_q <= stack_mem[stack_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= pwdata[VC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_INSERT;
			a_q         <= '0;
			b_q         <= '0;
			n_q         <= CW'(1);
			bad_q       <= 1'b0;
			edges_q     <= '0;
			row_valid_q <= '0;
			row_vld_q   <= 1'b0;
			visited_q   <= '0;
			cnt_q       <= '0;
			root_q      <= '0;
			depth_q     <= '0;
			top_q       <= '0;
			t_q         <= '0;
			v_q         <= '0;
		end else begin
			if (row_re) begin
				row_vld_q <= row_valid_q[row_raddr];
			end
			if (row_we) begin
				row_valid_q[row_waddr] <= 1'b1;
			end
			if (visit_en) begin
				visited_q[visit_ix] <= 1'b1;
				cnt_q               <= cnt_q + PRE_W'(1);
				depth_q             <= depth_q + CW'(1);
				top_q               <= visit_ix;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						kind_q <= kind;
						a_q    <= from_vertex;
						b_q    <= to_vertex;
						n_q    <= n_live;
						bad_q  <= 1'b0;
						case (kind)
							KIND_CLEAR: begin
								row_valid_q <= '0;
								edges_q     <= '0;
								state_q     <= S_DONE;
							end
							KIND_SEARCH: begin
								visited_q <= '0;
								cnt_q     <= '0;
								root_q    <= '0;
								depth_q   <= '0;
								state_q   <= S_ROOT;
							end
							default: begin
								if (in_range) begin
									state_q <= S_EA_RD;
								end else begin
									bad_q   <= 1'b1;
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_EA_RD: begin
					state_q <= S_EA_WR;
				end
				S_EA_WR: begin
					if ((kind_q == KIND_INSERT) && !row_eff[b_ix]) begin
						edges_q <= edges_q + EDGE_W'(1);
					end else if ((kind_q == KIND_REMOVE) && row_eff[b_ix]) begin
						edges_q <= edges_q - EDGE_W'(1);
					end
					state_q <= S_EB_RD;
				end
				S_EB_RD: begin
					state_q <= S_EB_WR;
				end
				S_EB_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ROOT: begin
					if (root_q == n_q) begin
						v_q     <= '0;
						state_q <= S_RPT_RD;
					end else if (visited_q[root_ix]) begin
						root_q <= root_q + CW'(1);
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					t_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit && can_push) begin
						state_q <= S_READ;
					end else if (hit || (t_q == n_q)) begin
						// drop back to the parent, or start the next tree
						depth_q <= depth_q - CW'(1);
						if (depth_q == CW'(1)) begin
							root_q  <= root_q + CW'(1);
							state_q <= S_ROOT;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						t_q <= t_q + CW'(1);
					end
				end
				S_POP: begin
					top_q   <= stack_rd_q;
					state_q <= S_READ;
				end
				S_RPT_RD: begin
					state_q <= S_RPT_OUT;
				end
				S_RPT_OUT: begin
					if (out_free) begin
						if (v_q + CW'(1) == n_q) begin
							state_q <= S_IDLE;
						end else begin
							v_q     <= v_q + CW'(1);
							state_q <= S_RPT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vertex_q     <= load_vertex;
			preorder_q   <= load_preorder;
			edge_count_q <= edges_q;
			bad_vertex_q <= load_bad;
			last_q       <= load_last;
		end
	end

	assign result_valid = out_valid_q;
	assign vertex       = vertex_q;
	assign preorder     = preorder_q;
	assign edge_count   = edge_count_q;
	assign bad_vertex   = bad_vertex_q;
	assign last         = last_q;

	a_depth_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= n_q)
		else $error("walk depth beyond live vertex count");

	a_visited_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT || state_q == S_SCAN) |-> ((visited_q >> n_q) == '0))
		else $error("vertex outside live range marked visited");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !item_ready)
		else $error("item taken without leaving idle");

	a_report_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RPT_OUT && out_load) |-> (v_q < n_q))
		else $error("reported vertex beyond live range");

endmodule

[verif/adjacency_matrix_dfs_preorder_test.sv]
// Self-checking bench for the adjacency matrix depth-first preorder block.
`timescale 1ns / 1ps
module adjacency_matrix_dfs_preorder_test;
	import amdfs_pkg::*;

	typedef struct {
		kind_t            op;
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
	} graph_op_t;

	typedef struct {
		logic [VTX_W-1:0]  vtx;
		logic [PRE_W-1:0]  pre;
		logic [EDGE_W-1:0] edges;
		logic              bad;
		logic              fin;
	} vertex_report_t;

	localparam int unsigned SPANS [10] = '{32, 1, 6, 17, 33, 63, 0, 12, 2, 32};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [KIND_W-1:0] kind = KIND_INSERT;
	logic [VTX_W-1:0] from_vertex = '0;
	logic [VTX_W-1:0] to_vertex = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [VTX_W-1:0] vertex;
	logic [PRE_W-1:0] preorder;
	logic [EDGE_W-1:0] edge_count;
	logic bad_vertex;
	logic last;

	graph_op_t graph_ops [$];
	vertex_report_t due_reports [$];
	logic [2*VTX_W-1:0] made_edges [$];
	graph_op_t next_op;

	logic [MAX_VERTICES_DEF-1:0] adj_rows [MAX_VERTICES_DEF];
	logic [EDGE_W-1:0] edge_total;
	logic [VC_W-1:0] vertex_count_reg;
	int unsigned mismatches;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned recv_gap;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	adjacency_matrix_dfs_preorder dut (.*);

	always #6 clk = ~clk;

	function automatic int live_count();
		int n;
		n = int'(vertex_count_reg);
		if (n == 0) n = 1;
		if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
		return n;
	endfunction

	function automatic int unsigned pick_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic walk_preorder(input int n);
		logic [MAX_VERTICES_DEF-1:0] seen;
		logic [PRE_W-1:0] order [MAX_VERTICES_DEF];
		logic [VTX_W-1:0] stack [MAX_VERTICES_DEF];
		logic [5:0] counter;
		int root, depth, top, t, v;
		bit found;
		vertex_report_t r;
		seen = '0;
		counter = '0;
		foreach (order[i]) order[i] = '0;
		for (root = 0; root < n; root++) begin
			if (seen[root]) continue;
			order[root] = counter[PRE_W-1:0];
			counter++;
			seen[root] = 1'b1;
			stack[0] = VTX_W'(root);
			depth = 1;
			while (depth > 0) begin
				top = int'(stack[depth-1]);
				found = 1'b0;
				for (t = 0; t < n; t++) begin
					if (adj_rows[top][t] && !seen[t]) begin
						found = 1'b1;
						break;
					end
				end
				if (found && depth < MAX_VERTICES_DEF) begin
					order[t] = counter[PRE_W-1:0];
					counter++;
					seen[t] = 1'b1;
					stack[depth] = VTX_W'(t);
					depth++;
				end else begin
					depth--;
				end
			end
		end
		for (v = 0; v < n; v++) begin
			r.vtx = VTX_W'(v);
			r.pre = order[v];
			r.edges = edge_total;
			r.bad = 1'b0;
			r.fin = (v == n - 1);
			due_reports.push_back(r);
		end
	endtask

	task automatic apply_op(input kind_t op, input logic [VTX_W-1:0] a,
			input logic [VTX_W-1:0] b);
		int n;
		vertex_report_t r;
		n = live_count();
		r.vtx = '0;
		r.pre = '0;
		r.bad = 1'b0;
		r.fin = 1'b1;
		case (op)
			KIND_SEARCH: begin
				walk_preorder(n);
			end
			KIND_CLEAR: begin
				foreach (adj_rows[i]) adj_rows[i] = '0;
				edge_total = '0;
				r.edges = edge_total;
				due_reports.push_back(r);
			end
			default: begin
				if (int'(a) >= n || int'(b) >= n) begin
					r.bad = 1'b1;
				end else if (op == KIND_INSERT) begin
					if (!adj_rows[a][b]) edge_total++;
					adj_rows[a][b] = 1'b1;
					adj_rows[b][a] = 1'b1;
				end else begin
					if (adj_rows[a][b]) edge_total--;
					adj_rows[a][b] = 1'b0;
					adj_rows[b][a] = 1'b0;
				end
				r.edges = edge_total;
				due_reports.push_back(r);
			end
		endcase
	endtask

	task automatic check_beat();
		vertex_report_t want;
		if (due_reports.size() == 0) begin
			report_mismatch("beat with nothing due", 32'(vertex), 0);
			return;
		end
		want = due_reports.pop_front();
		if (vertex !== want.vtx)
			report_mismatch("vertex", 32'(vertex), 32'(want.vtx));
		if (preorder !== want.pre)
			report_mismatch("preorder", 32'(preorder), 32'(want.pre));
		if (edge_count !== want.edges)
			report_mismatch("edge_count", 32'(edge_count), 32'(want.edges));
		if (bad_vertex !== want.bad)
			report_mismatch("bad_vertex", 32'(bad_vertex), 32'(want.bad));
		if (last !== want.fin)
			report_mismatch("last", 32'(last), 32'(want.fin));
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) send_calm <= ~send_calm;
		if ($urandom_range(0, 299) == 0) recv_calm <= ~recv_calm;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (item_valid && item_ready)
				apply_op(kind, from_vertex, to_vertex);
			if (!item_valid || item_ready) begin
				if (send_wait != 0) begin
					item_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (graph_ops.size() != 0) begin
					next_op = graph_ops.pop_front();
					item_valid <= 1'b1;
					kind <= next_op.op;
					from_vertex <= next_op.a;
					to_vertex <= next_op.b;
					send_wait <= pick_gap(send_calm);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_wait <= 0;
		end else if (result_valid && result_ready) begin
			check_beat();
			recv_gap = pick_gap(recv_calm);
			recv_wait <= recv_gap;
			result_ready <= (recv_gap == 0);
		end else if (recv_wait != 0) begin
			recv_wait <= recv_wait - 1;
			result_ready <= (recv_wait == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic queue_op(input kind_t op, input int unsigned a, input int unsigned b);
		graph_op_t g;
		g.op = op;
		g.a = VTX_W'(a);
		g.b = VTX_W'(b);
		graph_ops.push_back(g);
		if (op == KIND_INSERT) made_edges.push_back({g.a, g.b});
		if (op == KIND_CLEAR) made_edges.delete();
	endtask

	task automatic queue_random();
		int n, r, idx;
		int unsigned a, b;
		logic [2*VTX_W-1:0] e;
		n = live_count();
		r = $urandom_range(0, 99);
		if (r < 50) begin
			a = $urandom_range(0, n - 1);
			b = ($urandom_range(0, 9) == 0) ? a : $urandom_range(0, n - 1);
			queue_op(KIND_INSERT, a, b);
		end else if (r < 65) begin
			if (made_edges.size() != 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, made_edges.size() - 1);
				e = made_edges[idx];
				made_edges.delete(idx);
				if ($urandom_range(0, 1))
					queue_op(KIND_REMOVE, 32'(e[2*VTX_W-1:VTX_W]), 32'(e[VTX_W-1:0]));
				else
					queue_op(KIND_REMOVE, 32'(e[VTX_W-1:0]), 32'(e[2*VTX_W-1:VTX_W]));
			end else begin
				queue_op(KIND_REMOVE, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
			end
		end else if (r < 77) begin
			queue_op($urandom_range(0, 1) ? KIND_REMOVE : KIND_INSERT,
				$urandom_range(0, 31), $urandom_range(0, 31));
		end else if (r < 97) begin
			queue_op(KIND_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31));
		end else begin
			queue_op(KIND_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (graph_ops.size() != 0 || item_valid || due_reports.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_vertex_count(input int unsigned v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_VERTEX_COUNT_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		vertex_count_reg = v[VC_W-1:0];
	endtask

	initial begin
		foreach (adj_rows[i]) adj_rows[i] = '0;
		edge_total = '0;
		vertex_count_reg = VERTEX_COUNT_RESET;
		mismatches = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_op(KIND_INSERT, 0, 31);
		queue_op(KIND_INSERT, 31, 0);
		queue_op(KIND_INSERT, 5, 5);
		queue_op(KIND_INSERT, 3, 7);
		queue_op(KIND_REMOVE, 7, 3);
		queue_op(KIND_REMOVE, 7, 3);
		queue_op(KIND_INSERT, 31, 30);
		queue_op(KIND_SEARCH, 0, 0);
		queue_op(KIND_CLEAR, 31, 31);
		queue_op(KIND_SEARCH, 31, 31);
		settle();

		set_vertex_count(4);
		queue_op(KIND_INSERT, 0, 3);
		queue_op(KIND_INSERT, 4, 1);
		queue_op(KIND_INSERT, 1, 31);
		queue_op(KIND_REMOVE, 31, 31);
		queue_op(KIND_INSERT, 1, 2);
		queue_op(KIND_INSERT, 2, 0);
		queue_op(KIND_SEARCH, 0, 0);
		settle();

		set_vertex_count(0);
		queue_op(KIND_INSERT, 0, 0);
		queue_op(KIND_INSERT, 0, 1);
		queue_op(KIND_SEARCH, 0, 0);
		settle();

		set_vertex_count(63);
		queue_op(KIND_SEARCH, 0, 0);
		settle();

		set_vertex_count(32);
		queue_op(KIND_INSERT, 20, 25);
		settle();
		set_vertex_count(10);
		queue_op(KIND_SEARCH, 0, 0);
		queue_op(KIND_REMOVE, 20, 25);
		settle();

		foreach (SPANS[p]) begin
			set_vertex_count(SPANS[p]);
			repeat (19) queue_random();
			queue_op(KIND_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31));
			settle();
		end

		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("PASS adjacency_matrix_dfs_preorder");
		else
			$display("FAIL adjacency_matrix_dfs_preorder");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("FAIL adjacency_matrix_dfs_preorder");
		$finish;
	end

endmodule
